/* design/dcb_pkg.sv */
// Shared constants and types for the DC-blocking filter with RMS tracker.
// No dependencies; compile before every other design file.
package dcb_pkg;

  // Sample path
  localparam int SMP_W       = 16;
  localparam int ALPHA_W     = 15;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(32440);
  localparam int FRAC_W      = 15;                  // Q15 feedback
  localparam int PROD_W      = ALPHA_W + 1 + SMP_W; // signed alpha * y_prev
  localparam int SUM_W       = SMP_W + 3;           // x - x_prev + fb headroom

  // Block statistics
  localparam int MAX_BLOCK_SAMPLES = 4096;
  localparam int CNT_W       = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int MAG_W       = SMP_W - 1;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam int SQ_W        = 2 * MAG_W;
  localparam int ACC_W       = SQ_W + CNT_W;
  localparam int RMS_W       = MAG_W;

  // Shared subtract unit for divide and square root
  localparam int ROOT_W      = SQ_W + 1;
  localparam int DIV_STEPS   = ACC_W;
  localparam int SQRT_STEPS  = SQ_W / 2;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Background tracker (Q8)
  localparam int BG_FRAC     = 8;
  localparam int BG_W        = RMS_W + BG_FRAC;
  localparam int FALL_SHIFT  = 4;   // diff / 16
  localparam int RISE_SHIFT  = 7;   // diff / 128

  // Filter control from the top-level sequencer
  typedef struct packed {
    logic mul_en;   // register alpha * y_prev
    logic upd_en;   // form y, update filter history
  } hpf_ctrl_t;

endpackage

/* design/dcb_in_if.sv */
// Input sample channel: valid/ready handshake with sample and last flag.
// Depends on dcb_pkg.
interface dcb_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dcb_pkg::SMP_W-1:0]  sample;
  logic                              last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

/* design/dcb_out_if.sv */
// Result channel: filtered sample plus block statistics on the last sample.
// Depends on dcb_pkg.
interface dcb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dcb_pkg::SMP_W-1:0]  filtered_sample;
  logic                              stats_valid;
  logic        [dcb_pkg::RMS_W-1:0]  block_rms;
  logic        [dcb_pkg::RMS_W-1:0]  background_rms;

  modport source (output valid, output filtered_sample, output stats_valid,
                  output block_rms, output background_rms, input ready);
  modport sink   (input valid, input filtered_sample, input stats_valid,
                  input block_rms, input background_rms, output ready);
endinterface

/* design/dc_block_rms_noise_floor.sv */
// Top level of the DC-blocking filter with block RMS and background tracker.
// Depends on dcb_pkg, dcb_in_if, dcb_out_if, dcb_hpf and dcb_root.
//
// Each accepted sample is high-pass filtered and returned as one transaction
// on out_o. An ordinary sample passes through feedback multiply, filter,
// square, accumulate and output load before the next sample is taken. A
// sample marked last also runs the shared subtractor in dcb_root before
// the output load: 43 divide steps for the mean square and 15 square-root
// steps, framed by the start and done pulses, then the background update.
// in_i.ready is high only between samples; a finished result waits in the
// output register and does not hold off the next sample until a second
// result is ready. The high-pass feedback coefficient (Q15, reset 32440)
// is written with cfg_we_i and should only change while no sample is in
// flight.
module dc_block_rms_noise_floor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcb_pkg::ALPHA_W-1:0]   cfg_wdata_i,
  dcb_in_if.sink                        in_i,
  dcb_out_if.source                     out_o
);
  import dcb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_FILT, S_SQR, S_ACC, S_ROOT, S_BG, S_OUT
  } state_e;

  state_e              state_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic signed [SMP_W-1:0] x_q;
  logic                last_q;
  logic [SQ_W-1:0]     sq_q;
  logic [ACC_W-1:0]    acc_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [BG_W-1:0]     bg_q;
  logic                root_start_q;
  logic                out_valid_q;
  logic signed [SMP_W-1:0] out_y_q;
  logic                out_stats_q;
  logic [RMS_W-1:0]    out_rms_q;
  logic [RMS_W-1:0]    out_bg_q;

  hpf_ctrl_t               hpf_ctrl;
  logic signed [SMP_W-1:0] y;
  logic [SMP_W-1:0]        y_neg;
  logic [MAG_W-1:0]        mag;
  logic                    root_done;
  logic [RMS_W-1:0]        rms;
  logic [BG_W-1:0]         lvl;
  logic [BG_W-1:0]         fall;
  logic [BG_W-1:0]         rise;
  logic [BG_W-1:0]         bg_next;
  logic                    out_free;

  // Filter control
  always_comb begin
    hpf_ctrl.mul_en = (state_q == S_MUL);
    hpf_ctrl.upd_en = (state_q == S_FILT);
  end

  dcb_hpf u_hpf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .alpha_i (alpha_q),
    .ctrl_i  (hpf_ctrl),
    .x_i     (x_q),
    .y_o     (y)
  );

  dcb_root u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start_q),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .done_o     (root_done),
    .root_o     (rms)
  );

  // Magnitude clamped to MAG_MAX
  always_comb begin
    y_neg = -y;
    if (y == {1'b1, {(SMP_W-1){1'b0}}}) begin
      mag = MAG_MAX;
    end else if (y[SMP_W-1]) begin
      mag = y_neg[MAG_W-1:0];
    end else begin
      mag = y[MAG_W-1:0];
    end
  end

  // Background level: seed, then fall by diff/16 or rise by diff/128, min 1
  always_comb begin
    lvl  = {((rms == '0) ? RMS_W'(1) : rms), {BG_FRAC{1'b0}}};
    fall = (bg_q - lvl) >> FALL_SHIFT;
    rise = (lvl - bg_q) >> RISE_SHIFT;
    if (bg_q == '0) begin
      bg_next = lvl;
    end else if (lvl < bg_q) begin
      bg_next = bg_q - ((fall == '0) ? BG_W'(1) : fall);
    end else begin
      bg_next = bg_q + ((rise == '0) ? BG_W'(1) : rise);
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer, block statistics and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      alpha_q      <= ALPHA_RESET;
      acc_q        <= '0;
      cnt_q        <= '0;
      bg_q         <= '0;
      root_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      root_start_q <= 1'b0;
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:  state_q <= S_FILT;
        S_FILT: state_q <= S_SQR;
        S_SQR:  state_q <= S_ACC;
        S_ACC: begin
          if (cnt_q < CNT_W'(MAX_BLOCK_SAMPLES)) begin
            acc_q <= acc_q + ACC_W'(sq_q);
            cnt_q <= cnt_q + 1'b1;
          end
          if (last_q) begin
            root_start_q <= 1'b1;
            state_q      <= S_ROOT;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state_q <= S_BG;
          end
        end
        S_BG: begin
          bg_q    <= bg_next;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      x_q    <= in_i.sample;
      last_q <= in_i.last;
    end
    if (state_q == S_SQR) begin
      sq_q <= mag * mag;
    end
    if (state_q == S_OUT && out_free) begin
      out_y_q     <= y;
      out_stats_q <= last_q;
      out_rms_q   <= last_q ? rms : '0;
      out_bg_q    <= last_q ? bg_q[BG_W-1:BG_FRAC] : '0;
    end
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_y_q;
  assign out_o.stats_valid     = out_stats_q;
  assign out_o.block_rms       = out_rms_q;
  assign out_o.background_rms  = out_bg_q;

endmodule

/* design/dcb_hpf.sv */
// First-order DC-blocking high-pass: y = x - x_prev + round(alpha*y_prev).
// Depends on dcb_pkg; sequenced by the top level through hpf_ctrl_t.
module dcb_hpf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [dcb_pkg::ALPHA_W-1:0]       alpha_i,
  input  dcb_pkg::hpf_ctrl_t                ctrl_i,
  input  logic signed [dcb_pkg::SMP_W-1:0]  x_i,
  output logic signed [dcb_pkg::SMP_W-1:0]  y_o
);
  import dcb_pkg::*;

  logic signed [SMP_W-1:0]  prior_in_q;
  logic signed [SMP_W-1:0]  prior_out_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] fb_full;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SMP_W-1:0]  y_sat;

  // Rounded feedback, floor shift, then sum with saturation
  always_comb begin
    fb_full = (prod_q + PROD_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
    sum     = {{(SUM_W-SMP_W){x_i[SMP_W-1]}}, x_i}
            - {{(SUM_W-SMP_W){prior_in_q[SMP_W-1]}}, prior_in_q}
            + fb_full[SUM_W-1:0];
    if (sum[SUM_W-1:SMP_W-1] == '0 || sum[SUM_W-1:SMP_W-1] == '1) begin
      y_sat = sum[SMP_W-1:0];
    end else if (sum[SUM_W-1]) begin
      y_sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  // Feedback product and filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_in_q  <= '0;
      prior_out_q <= '0;
    end else if (ctrl_i.upd_en) begin
      prior_in_q  <= x_i;
      prior_out_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= $signed({1'b0, alpha_i}) * prior_out_q;
    end
  end

  assign y_o = prior_out_q;

endmodule

/* design/dcb_root.sv */
// Shared subtract/compare unit: restoring divide of the square sum by the
// sample count, then bitwise floor square root of the quotient. Uses dcb_pkg.
module dcb_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dcb_pkg::ACC_W-1:0]   dividend_i,
  input  logic [dcb_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [dcb_pkg::RMS_W-1:0]   root_o
);
  import dcb_pkg::*;

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_e;

  rstate_e           state_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [ACC_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SQ_W-1:0]   quo_q;
  logic [SQ_W-1:0]   val_q;
  logic [ROOT_W-1:0] res_q;
  logic [ROOT_W-1:0] bit_q;

  logic [ROOT_W-1:0] op_a;
  logic [ROOT_W-1:0] op_b;
  logic [ROOT_W:0]   diff;
  logic              ge;

  // Operand select for the one subtractor
  always_comb begin
    if (state_q == R_SQRT) begin
      op_a = {1'b0, val_q};
      op_b = res_q + bit_q;
    end else begin
      op_a = ROOT_W'({rem_q, dvd_q[ACC_W-1]});
      op_b = ROOT_W'(dsr_q);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[ROOT_W];
  end

  // Sequencer: divide steps, then root steps, then a done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_DIV;
            step_q  <= STEP_W'(DIV_STEPS - 1);
          end
        end
        R_DIV: begin
          if (step_q == '0) begin
            state_q <= R_SQRT;
            step_q  <= STEP_W'(SQRT_STEPS - 1);
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        R_SQRT: begin
          if (step_q == '0) begin
            state_q <= R_IDLE;
            done_q  <= 1'b1;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          dvd_q <= dividend_i;
          dsr_q <= divisor_i;
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      R_DIV: begin
        dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
        rem_q <= ge ? diff[CNT_W-1:0] : op_a[CNT_W-1:0];
        quo_q <= {quo_q[SQ_W-2:0], ge};
        if (step_q == '0) begin
          // Quotient is below 2^SQ_W since each term is at most MAG_MAX^2
          val_q <= {quo_q[SQ_W-2:0], ge};
          res_q <= '0;
          bit_q <= ROOT_W'(1) << (SQ_W - 2);
        end
      end
      R_SQRT: begin
        if (ge) begin
          val_q <= diff[SQ_W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = res_q[RMS_W-1:0];

endmodule
